// File: rtl/core/humidity_temp_convert_average_macros.svh
// ---------------------------------------------------------------------------
// humidity_temp_convert_average assertion macros
// shared property forms for the conversion and averaging block
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_CONVERT_AVERAGE_MACROS_SVH
`define HUMIDITY_TEMP_CONVERT_AVERAGE_MACROS_SVH

// same-cycle implication
`define HTCA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/htca_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htca_pkg
// constants and types of the humidity and temperature averaging block
// ---------------------------------------------------------------------------
package htca_pkg;

   localparam int unsigned CODE_WIDTH  = 20;
   localparam int unsigned CODE_SHIFT  = 20;
   localparam int unsigned DEPTH       = 3;
   localparam int unsigned DIV_WIDTH   = 13;
   localparam int unsigned DIV_STEPS   = DIV_WIDTH;

   localparam logic [6:0] HUM_SPAN    = 7'd100;
   localparam logic [7:0] TEMP_SPAN   = 8'd200;
   localparam logic [8:0] TEMP_OFFSET = 9'd50;
   localparam logic [7:0] NIBBLE_MASK = 8'b0000_1111;
   localparam logic [1:0] COUNT_MAX   = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CONV  = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_TDIV  = 7'b0001000,
      ST_HLOAD = 7'b0010000,
      ST_HDIV  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/humidity_temp_convert_average.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// humidity_temp_convert_average
// sensor frame conversion with a three-sample moving average
// ---------------------------------------------------------------------------
// One frame is taken per transfer and gives one result: a conversion state
// and a summing state come first, then one shared restoring divider
// runs 13 steps for the temperature mean, a load state sets the humidity
// numerator, 13 more steps give the humidity mean and a done state writes the
// output register. The input stalls while a frame is being worked on, so a
// new frame is taken only once the last one is in the output register. A
// finished result waits in the output register, so the next frame can be
// taken before it is read; if that result is still unread when the next one
// is ready, the block holds in its done state and the input stays stalled.
// ---------------------------------------------------------------------------
`include "humidity_temp_convert_average_macros.svh"

module humidity_temp_convert_average (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_humidity_high_byte,
   input  logic [7:0]        req_humidity_mid_byte,
   input  logic [7:0]        req_shared_byte,
   input  logic [7:0]        req_temp_mid_byte,
   input  logic [7:0]        req_temp_low_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [8:0] rsp_temp_mean_degrees,
   output logic [9:0]        rsp_humidity_mean_tenths,
   output logic [1:0]        rsp_samples_used
);

   localparam int unsigned CW = htca_pkg::CODE_WIDTH;
   localparam int unsigned DW = htca_pkg::DIV_WIDTH;

   htca_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  hum_code_ff, hum_code_in;
   logic [CW-1:0]  temp_code_ff, temp_code_in;
   logic [8:0]     temp_hist_ff [htca_pkg::DEPTH];
   logic [8:0]     temp_hist_in [htca_pkg::DEPTH];
   logic [6:0]     hum_hist_ff  [htca_pkg::DEPTH];
   logic [6:0]     hum_hist_in  [htca_pkg::DEPTH];
   logic [1:0]     count_ff, count_in;
   logic           tneg_ff, tneg_in;
   logic [8:0]     hsum_ff, hsum_in;
   logic [8:0]     tmean_ff, tmean_in;
   logic [DW-1:0]  div_quot_ff, div_quot_in;
   logic [2:0]     div_rem_ff, div_rem_in;
   logic [2:0]     div_den_ff, div_den_in;
   logic [3:0]     div_count_ff, div_count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [8:0]     rsp_temp_ff, rsp_temp_in;
   logic [9:0]     rsp_hum_ff, rsp_hum_in;
   logic [1:0]     rsp_used_ff, rsp_used_in;

   logic           req_xfer;
   logic           rsp_xfer;
   logic [3:0]     temp_hi_nib;
   logic [26:0]    hum_prod;
   logic [27:0]    temp_prod;
   logic [8:0]     temp_deg;
   logic [10:0]    tsum;
   logic [10:0]    tmag;
   logic [8:0]     hsum;
   logic [3:0]     trial;
   logic           trial_ge;
   logic [3:0]     trial_diff;
   logic           div_last;

   assign req_xfer    = req_valid && !req_stall;
   assign rsp_xfer    = rsp_valid_ff && !rsp_stall;
   assign req_stall   = (state_ff != htca_pkg::ST_IDLE);
   assign temp_hi_nib = 4'(req_shared_byte & htca_pkg::NIBBLE_MASK);

   // conversion products
   assign hum_prod  = 27'(hum_code_ff) * 27'(htca_pkg::HUM_SPAN);
   assign temp_prod = 28'(temp_code_ff) * 28'(htca_pkg::TEMP_SPAN);
   assign temp_deg  = {1'b0, temp_prod[htca_pkg::CODE_SHIFT +: 8]} - htca_pkg::TEMP_OFFSET;

   // sums over the history, entries never written stay zero
   assign tsum = {{2{temp_hist_ff[0][8]}}, temp_hist_ff[0]}
               + {{2{temp_hist_ff[1][8]}}, temp_hist_ff[1]}
               + {{2{temp_hist_ff[2][8]}}, temp_hist_ff[2]};
   assign tmag = tsum[10] ? (11'd0 - tsum) : tsum;
   assign hsum = 9'(hum_hist_ff[0]) + 9'(hum_hist_ff[1]) + 9'(hum_hist_ff[2]);

   // shared restoring divider step
   assign trial      = {div_rem_ff, div_quot_ff[DW-1]};
   assign trial_ge   = (trial >= {1'b0, div_den_ff});
   assign trial_diff = trial - {1'b0, div_den_ff};
   assign div_last   = (div_count_ff == 4'(htca_pkg::DIV_STEPS - 1));

   always_comb begin
      state_in     = state_ff;
      hum_code_in  = hum_code_ff;
      temp_code_in = temp_code_ff;
      temp_hist_in = temp_hist_ff;
      hum_hist_in  = hum_hist_ff;
      count_in     = count_ff;
      tneg_in      = tneg_ff;
      hsum_in      = hsum_ff;
      tmean_in     = tmean_ff;
      div_quot_in  = div_quot_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_count_in = div_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_temp_in  = rsp_temp_ff;
      rsp_hum_in   = rsp_hum_ff;
      rsp_used_in  = rsp_used_ff;

      case (state_ff)
         htca_pkg::ST_IDLE: begin
            if (req_xfer) begin
               hum_code_in  = {req_humidity_high_byte, req_humidity_mid_byte,
                               req_shared_byte[7:4]};
               temp_code_in = {temp_hi_nib, req_temp_mid_byte, req_temp_low_byte};
               state_in     = htca_pkg::ST_CONV;
            end
         end
         htca_pkg::ST_CONV: begin
            temp_hist_in[2] = temp_hist_ff[1];
            temp_hist_in[1] = temp_hist_ff[0];
            temp_hist_in[0] = temp_deg;
            hum_hist_in[2]  = hum_hist_ff[1];
            hum_hist_in[1]  = hum_hist_ff[0];
            hum_hist_in[0]  = hum_prod[htca_pkg::CODE_SHIFT +: 7];
            if (count_ff != htca_pkg::COUNT_MAX) begin
               count_in = count_ff + 2'd1;
            end
            state_in = htca_pkg::ST_SUM;
         end
         htca_pkg::ST_SUM: begin
            tneg_in      = tsum[10];
            hsum_in      = hsum;
            div_quot_in  = DW'({tmag[8:0], 1'b0}) + DW'(count_ff);
            div_rem_in   = 3'd0;
            div_den_in   = {count_ff, 1'b0};
            div_count_in = 4'd0;
            state_in     = htca_pkg::ST_TDIV;
         end
         htca_pkg::ST_TDIV, htca_pkg::ST_HDIV: begin
            div_quot_in  = {div_quot_ff[DW-2:0], trial_ge};
            div_rem_in   = trial_ge ? trial_diff[2:0] : trial[2:0];
            div_count_in = div_count_ff + 4'd1;
            if (div_last) begin
               state_in = (state_ff == htca_pkg::ST_TDIV) ? htca_pkg::ST_HLOAD
                                                          : htca_pkg::ST_DONE;
            end
         end
         htca_pkg::ST_HLOAD: begin
            tmean_in     = tneg_ff ? (9'd0 - div_quot_ff[8:0]) : div_quot_ff[8:0];
            div_quot_in  = (DW'(hsum_ff) << 4) + (DW'(hsum_ff) << 2) + DW'(count_ff);
            div_rem_in   = 3'd0;
            div_count_in = 4'd0;
            state_in     = htca_pkg::ST_HDIV;
         end
         htca_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = tmean_ff;
               rsp_hum_in   = div_quot_ff[9:0];
               rsp_used_in  = count_ff;
               state_in     = htca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htca_pkg::ST_IDLE;
         count_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < htca_pkg::DEPTH; i++) begin
            temp_hist_ff[i] <= 9'd0;
            hum_hist_ff[i]  <= 7'd0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         temp_hist_ff <= temp_hist_in;
         hum_hist_ff  <= hum_hist_in;
      end
      hum_code_ff  <= hum_code_in;
      temp_code_ff <= temp_code_in;
      tneg_ff      <= tneg_in;
      hsum_ff      <= hsum_in;
      tmean_ff     <= tmean_in;
      div_quot_ff  <= div_quot_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_count_ff <= div_count_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_hum_ff   <= rsp_hum_in;
      rsp_used_ff  <= rsp_used_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_temp_mean_degrees    = rsp_temp_ff;
   assign rsp_humidity_mean_tenths = rsp_hum_ff;
   assign rsp_samples_used         = rsp_used_ff;

   `HTCA_ASSERT_NEXT(a_accept_starts_conv, clock, reset, req_xfer, state_ff == htca_pkg::ST_CONV, "accepted frame did not start conversion")
   `HTCA_ASSERT_IMPLY(a_div_count_range, clock, reset, (state_ff == htca_pkg::ST_TDIV) || (state_ff == htca_pkg::ST_HDIV), div_count_ff < 4'(htca_pkg::DIV_STEPS), "divider step count out of range")
   `HTCA_ASSERT_IMPLY(a_rsp_used_nonzero, clock, reset, rsp_valid_ff, rsp_used_ff != 2'd0, "result with zero samples")
   `HTCA_ASSERT_IMPLY(a_rsp_hum_range, clock, reset, rsp_valid_ff, rsp_hum_ff <= 10'd990, "humidity mean above range")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks sensor frame conversion and the three-sample moving average
// ---------------------------------------------------------------------------
// A table of frames runs first: the extreme codes, temperatures just below
// zero, the first two samples after reset and the drop of the oldest sample.
// A few rows carry their result typed in. Random frames follow. Each other result
// is compared field by field with a running copy of the averaging state.
// Both sides idle and stall at random, with stretches of no gaps.
// ---------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic signed [8:0] temp;
      logic [9:0]        hum;
      logic [1:0]        used;
   } mean_type;

   typedef struct packed {
      bit       typed;
      mean_type val;
   } typed_mean_type;

   typedef struct packed {
      logic [7:0] hh;
      logic [7:0] hm;
      logic [7:0] sh;
      logic [7:0] tm;
      logic [7:0] tl;
      bit         typed;
      mean_type   val;
   } frame_row_type;

   localparam int FRAME_ROWS   = 20;
   localparam int RANDOM_ITEMS = 400;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_humidity_high_byte;
   logic [7:0]        req_humidity_mid_byte;
   logic [7:0]        req_shared_byte;
   logic [7:0]        req_temp_mid_byte;
   logic [7:0]        req_temp_low_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic signed [8:0] rsp_temp_mean_degrees;
   logic [9:0]        rsp_humidity_mean_tenths;
   logic [1:0]        rsp_samples_used;

   int             temp_hist [3];
   int             hum_hist [3];
   int             seen;
   int             errors;
   bit             req_quiet;
   bit             rsp_quiet;
   typed_mean_type typed_means [$];
   mean_type       pending_means [$];

   frame_row_type frame_rows [FRAME_ROWS] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{-9'sd50, 10'd0, 2'd1}},
      '{8'hFF, 8'hFF, 8'hF3, 8'hEB, 8'h86, 1'b1, '{-9'sd26, 10'd495, 2'd2}},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{9'sd149, 10'd990, 2'd3}},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{-9'sd50, 10'd0, 2'd3}},
      '{8'h80, 8'h00, 8'h04, 8'h00, 8'h00, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h7F, 8'hFF, 8'hF3, 8'hFF, 8'hFF, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h01, 8'h02, 8'h33, 8'hEB, 8'h86, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'hAA, 8'h55, 8'hA5, 8'h5A, 8'hA5, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h55, 8'hAA, 8'h5A, 8'hA5, 8'h5A, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h76, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h80, 8'h80, 8'h88, 8'h80, 8'h80, 1'b0, '{9'sd0, 10'd0, 2'd0}},
      '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 1'b0, '{9'sd0, 10'd0, 2'd0}}
   };

   humidity_temp_convert_average u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_humidity_high_byte   (req_humidity_high_byte),
      .req_humidity_mid_byte    (req_humidity_mid_byte),
      .req_shared_byte          (req_shared_byte),
      .req_temp_mid_byte        (req_temp_mid_byte),
      .req_temp_low_byte        (req_temp_low_byte),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_temp_mean_degrees    (rsp_temp_mean_degrees),
      .rsp_humidity_mean_tenths (rsp_humidity_mean_tenths),
      .rsp_samples_used         (rsp_samples_used)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // shift in one frame and return the mean over the kept samples
   function automatic mean_type advance_average(input logic [7:0] hh, input logic [7:0] hm,
                                                input logic [7:0] sh, input logic [7:0] tm,
                                                input logic [7:0] tl);
      logic [19:0] hum_code;
      logic [19:0] temp_code;
      longint      hum_pct;
      longint      temp_deg;
      longint      tsum;
      longint      hsum;
      longint      n;
      int          i;
      mean_type    r;
      hum_code  = {hh, hm, sh[7:4]};
      temp_code = {sh[3:0], tm, tl};
      hum_pct   = (longint'(hum_code) * 100) >> 20;
      temp_deg  = ((longint'(temp_code) * 200) >> 20) - 50;
      temp_hist[2] = temp_hist[1];
      temp_hist[1] = temp_hist[0];
      temp_hist[0] = int'(temp_deg);
      hum_hist[2]  = hum_hist[1];
      hum_hist[1]  = hum_hist[0];
      hum_hist[0]  = int'(hum_pct) & 'h7F;
      if (seen < 3) begin
         seen++;
      end
      n    = seen;
      tsum = 0;
      hsum = 0;
      for (i = 0; i < seen; i++) begin
         tsum += temp_hist[i];
         hsum += hum_hist[i];
      end
      // round half away from zero
      if (tsum >= 0) begin
         r.temp = 9'((2 * tsum + n) / (2 * n));
      end else begin
         r.temp = 9'(-((-2 * tsum + n) / (2 * n)));
      end
      r.hum  = 10'((20 * hsum + n) / (2 * n));
      r.used = 2'(n);
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic send_frame(input logic [7:0] hh, input logic [7:0] hm, input logic [7:0] sh,
                             input logic [7:0] tm, input logic [7:0] tl, input bit typed,
                             input mean_type val);
      int             gap;
      typed_mean_type entry;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) begin
         req_quiet = !req_quiet;
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_humidity_high_byte <= hh;
      req_humidity_mid_byte  <= hm;
      req_shared_byte        <= sh;
      req_temp_mid_byte      <= tm;
      req_temp_low_byte      <= tl;
      req_valid              <= 1'b1;
      entry.typed = typed;
      entry.val   = val;
      typed_means.push_back(entry);
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // result side: random stall before each transfer
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      rsp_quiet = 1'b0;
      @(negedge reset);
      forever begin
         wait_cycles = rsp_quiet ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 19) == 0) begin
            rsp_quiet = !rsp_quiet;
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      typed_mean_type entry;
      mean_type       want;
      mean_type       predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = advance_average(req_humidity_high_byte, req_humidity_mid_byte,
                                        req_shared_byte, req_temp_mid_byte,
                                        req_temp_low_byte);
            entry = typed_means.pop_front();
            pending_means.push_back(entry.typed ? entry.val : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_means.size() == 0) begin
               $display("%0t unexpected transfer: temp %0d humidity %0d samples %0d", $time,
                        rsp_temp_mean_degrees, rsp_humidity_mean_tenths, rsp_samples_used);
               errors++;
            end else begin
               want = pending_means.pop_front();
               if (rsp_temp_mean_degrees !== want.temp) begin
                  $display("%0t temp_mean_degrees expected %0d actual %0d", $time,
                           want.temp, rsp_temp_mean_degrees);
                  errors++;
               end
               if (rsp_humidity_mean_tenths !== want.hum) begin
                  $display("%0t humidity_mean_tenths expected %0d actual %0d", $time,
                           want.hum, rsp_humidity_mean_tenths);
                  errors++;
               end
               if (rsp_samples_used !== want.used) begin
                  $display("%0t samples_used expected %0d actual %0d", $time,
                           want.used, rsp_samples_used);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int       k;
      mean_type none;
      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_humidity_high_byte = 8'h00;
      req_humidity_mid_byte  = 8'h00;
      req_shared_byte        = 8'h00;
      req_temp_mid_byte      = 8'h00;
      req_temp_low_byte      = 8'h00;
      req_quiet              = 1'b0;
      errors                 = 0;
      seen                   = 0;
      none                   = '0;
      for (k = 0; k < 3; k++) begin
         temp_hist[k] = 0;
         hum_hist[k]  = 0;
      end
      repeat (3) begin
         @(posedge clock);
      end
      @(negedge clock);
      reset <= 1'b0;
      for (k = 0; k < FRAME_ROWS; k++) begin
         send_frame(frame_rows[k].hh, frame_rows[k].hm, frame_rows[k].sh, frame_rows[k].tm,
                    frame_rows[k].tl, frame_rows[k].typed, frame_rows[k].val);
      end
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         send_frame(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(), 1'b0,
                    none);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_means.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) begin
         @(posedge clock);
      end
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: humidity_temp_convert_average.f
+incdir+rtl/core
rtl/core/htca_pkg.sv
rtl/core/humidity_temp_convert_average.sv
tb/testbench.sv
